// ----- src/rgbhsl_pkg.sv -----
// ----------------------------------------------------------------------------
// rgbhsl_pkg
// Shared widths and the restoring-division step for the RGB to HSL core.
// ----------------------------------------------------------------------------
package rgbhsl_pkg;

   // Width of one color component and of each result field
   localparam int unsigned CH_W  = 8;
   // Quotient bits per division, one pipeline stage each
   localparam int unsigned QUO_W = 8;
   // Dividend / partial remainder width (hue dividend stays below 2^20)
   localparam int unsigned REM_W = 20;
   // Divisor width (twice six times the spread stays below 2^12)
   localparam int unsigned DEN_W = 12;

   // Result of one division step: quotient bit on top, new remainder below
   typedef struct packed {
      logic             qbit;
      logic [REM_W-1:0] rem;
   } div_step_type;

   // One restoring step: try to take den << shift out of the remainder
   function automatic div_step_type div_step(input logic [REM_W-1:0] rem,
                                             input logic [DEN_W-1:0] den,
                                             input int unsigned shift);
      logic [REM_W-1:0] trial;
      div_step_type     res;
      trial = REM_W'(den) << shift;
      if (rem >= trial) begin
         res.qbit = 1'b1;
         res.rem  = rem - trial;
      end else begin
         res.qbit = 1'b0;
         res.rem  = rem;
      end
      return res;
   endfunction

endpackage

// ----- src/rgb_to_hsl_pixel_core.sv -----
// ----------------------------------------------------------------------------
// rgb_to_hsl_pixel_core
// Converts one 8-bit RGB pixel to 8-bit hue, lightness and saturation,
// each rounded half up, through a fully pipelined pair of dividers.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  request   in   start / busy         req_red, req_green, req_blue
//  response  out  rsp_valid (strobe)   rsp_hue, rsp_lightness, rsp_saturation
//
//  One request per clock; busy is held low, so a request is taken whenever
//  start is high. Each response passes through three front stages (min/max,
//  spread and sector, dividend setup) and eight restoring-division stages,
//  one quotient bit each, for hue and saturation. Synchronous reset clears
//  the valid bits only; requests in flight are dropped. The receiver cannot
//  stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module rgb_to_hsl_pixel_core
   import rgbhsl_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  logic [CH_W-1:0] req_red,
   input  logic [CH_W-1:0] req_green,
   input  logic [CH_W-1:0] req_blue,
   output logic            rsp_valid,
   output logic [CH_W-1:0] rsp_hue,
   output logic [CH_W-1:0] rsp_lightness,
   output logic [CH_W-1:0] rsp_saturation
);

   localparam int unsigned SUM_W = CH_W + 1;
   localparam int unsigned N_W   = 11;

   // Never refuse a request
   assign busy = 1'b0;

   logic accept;
   assign accept = start && !busy;

   // ------------------------------------------------------------------
   // Stage 1: max and min of the three components
   // ------------------------------------------------------------------
   logic            v1_ff;
   logic [CH_W-1:0] r1_ff, g1_ff, b1_ff, mx1_ff, mn1_ff;
   logic [CH_W-1:0] mx1_in, mn1_in;

   always_comb begin
      mx1_in = req_red;
      mn1_in = req_red;
      if (req_green > mx1_in) mx1_in = req_green;
      if (req_blue  > mx1_in) mx1_in = req_blue;
      if (req_green < mn1_in) mn1_in = req_green;
      if (req_blue  < mn1_in) mn1_in = req_blue;
   end

   always_ff @(posedge clock) begin
      r1_ff  <= req_red;
      g1_ff  <= req_green;
      b1_ff  <= req_blue;
      mx1_ff <= mx1_in;
      mn1_ff <= mn1_in;
   end

   // ------------------------------------------------------------------
   // Stage 2: spread, lightness, saturation divisor, hue sector numerator
   // ------------------------------------------------------------------
   logic            v2_ff;
   logic [CH_W-1:0] d2_ff, lit2_ff, den2_ff;
   logic [N_W-1:0]  n2_ff;
   logic [CH_W-1:0] d2_in, lit2_in, den2_in;
   logic [N_W-1:0]  n2_in;
   logic [SUM_W-1:0] sum2;
   logic [N_W-1:0]  d6;

   always_comb begin
      d2_in   = mx1_ff - mn1_ff;
      sum2    = SUM_W'(mx1_ff) + SUM_W'(mn1_ff);
      lit2_in = CH_W'((10'(sum2) + 10'd1) >> 1);
      if (sum2 <= SUM_W'(255)) begin
         den2_in = sum2[CH_W-1:0];
      end else begin
         den2_in = CH_W'(SUM_W'(510) - sum2);
      end
      d6 = (N_W'(d2_in) << 2) + (N_W'(d2_in) << 1);
      // Red wins ties, then green, then blue
      if (r1_ff == mx1_ff) begin
         if (g1_ff < b1_ff) begin
            n2_in = d6 - N_W'(b1_ff - g1_ff);
         end else begin
            n2_in = N_W'(g1_ff - b1_ff);
         end
      end else if (g1_ff == mx1_ff) begin
         n2_in = (N_W'(d2_in) << 1) + N_W'(b1_ff) - N_W'(r1_ff);
      end else begin
         n2_in = (N_W'(d2_in) << 2) + N_W'(r1_ff) - N_W'(g1_ff);
      end
   end

   always_ff @(posedge clock) begin
      d2_ff   <= d2_in;
      lit2_ff <= lit2_in;
      den2_ff <= den2_in;
      n2_ff   <= n2_in;
   end

   // ------------------------------------------------------------------
   // Division pipeline; index 0 is the dividend setup stage
   // Rounded quotient = floor((2*255*num + den) / (2*den))
   // ------------------------------------------------------------------
   logic             vld_ff  [0:QUO_W];
   logic             gray_ff [0:QUO_W];
   logic [CH_W-1:0]  lit_ff  [0:QUO_W];
   logic [REM_W-1:0] hrem_ff [0:QUO_W];
   logic [DEN_W-1:0] hden_ff [0:QUO_W];
   logic [QUO_W-1:0] hq_ff   [0:QUO_W];
   logic [REM_W-1:0] srem_ff [0:QUO_W];
   logic [DEN_W-1:0] sden_ff [0:QUO_W];
   logic [QUO_W-1:0] sq_ff   [0:QUO_W];

   logic [REM_W-1:0] hnum0_in, snum0_in;
   logic [DEN_W-1:0] hden0_in, sden0_in;

   // Set up dividends and divisors (510*x as shift and subtract)
   always_comb begin
      hnum0_in = (REM_W'(n2_ff) << 9) - (REM_W'(n2_ff) << 1)
               + (REM_W'(d2_ff) << 2) + (REM_W'(d2_ff) << 1);
      hden0_in = (DEN_W'(d2_ff) << 3) + (DEN_W'(d2_ff) << 2);
      snum0_in = (REM_W'(d2_ff) << 9) - (REM_W'(d2_ff) << 1) + REM_W'(den2_ff);
      sden0_in = DEN_W'(den2_ff) << 1;
   end

   always_ff @(posedge clock) begin
      gray_ff[0] <= (d2_ff == '0);
      lit_ff[0]  <= lit2_ff;
      hrem_ff[0] <= hnum0_in;
      hden_ff[0] <= hden0_in;
      hq_ff[0]   <= '0;
      srem_ff[0] <= snum0_in;
      sden_ff[0] <= sden0_in;
      sq_ff[0]   <= '0;
   end

   // One quotient bit per stage, most significant first
   for (genvar j = 0; j < QUO_W; j++) begin : g_div
      div_step_type hstep_in, sstep_in;

      always_comb begin
         hstep_in = div_step(hrem_ff[j], hden_ff[j], QUO_W - 1 - j);
         sstep_in = div_step(srem_ff[j], sden_ff[j], QUO_W - 1 - j);
      end

      always_ff @(posedge clock) begin
         gray_ff[j+1] <= gray_ff[j];
         lit_ff[j+1]  <= lit_ff[j];
         hrem_ff[j+1] <= hstep_in.rem;
         hden_ff[j+1] <= hden_ff[j];
         hq_ff[j+1]   <= {hq_ff[j][QUO_W-2:0], hstep_in.qbit};
         srem_ff[j+1] <= sstep_in.rem;
         sden_ff[j+1] <= sden_ff[j];
         sq_ff[j+1]   <= {sq_ff[j][QUO_W-2:0], sstep_in.qbit};
      end
   end

   // ------------------------------------------------------------------
   // Valid bits travel with the data
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         for (int i = 0; i <= QUO_W; i++) vld_ff[i] <= 1'b0;
      end else begin
         v1_ff     <= accept;
         v2_ff     <= v1_ff;
         vld_ff[0] <= v2_ff;
         for (int i = 1; i <= QUO_W; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // Drive the response; gray pixels force hue and saturation to zero
   assign rsp_valid      = vld_ff[QUO_W];
   assign rsp_lightness  = lit_ff[QUO_W];
   assign rsp_hue        = gray_ff[QUO_W] ? '0 : hq_ff[QUO_W];
   assign rsp_saturation = gray_ff[QUO_W] ? '0 : sq_ff[QUO_W];

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##11 rsp_valid)
      else $error("request did not produce a response after 11 cycles");

   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[0] && !gray_ff[0]) |->
         (hrem_ff[0] < (REM_W'(hden_ff[0]) << QUO_W)))
      else $error("hue dividend exceeds quotient range");

   a_hue_rem: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[QUO_W] && !gray_ff[QUO_W]) |->
         (hrem_ff[QUO_W] < REM_W'(hden_ff[QUO_W])))
      else $error("hue remainder not below divisor");

   a_sat_rem: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[QUO_W] && !gray_ff[QUO_W]) |->
         (srem_ff[QUO_W] < REM_W'(sden_ff[QUO_W])))
      else $error("saturation remainder not below divisor");

endmodule

// ----- bench/rgb_to_hsl_pixel_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsl_pixel_core_tb
// Drives RGB pixels into the converter in bursts with random gaps, predicts
// hue, lightness and saturation for every accepted request, and checks each
// strobed response in order against those predictions.
// ----------------------------------------------------------------------------
module rgb_to_hsl_pixel_core_tb;
   import rgbhsl_pkg::*;

   localparam int unsigned IDLE_LIMIT   = 1000;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned RANDOM_PIXELS = 1750;
   localparam int unsigned REPORT_LIMIT = 10;

   // One predicted conversion, with the pixel kept for reporting
   typedef struct {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      logic [CH_W-1:0] hue;
      logic [CH_W-1:0] lightness;
      logic [CH_W-1:0] saturation;
   } hsl_pixel_type;

   // Predicts conversions and matches responses against them in order
   class hsl_scoreboard;
      hsl_pixel_type pending_q[$];
      int unsigned   fail_count;

      function new();
         fail_count = 0;
      endfunction

      // Rounded half up quotient of an exact fraction
      function bit [31:0] round_half_up(bit [31:0] num, bit [31:0] den);
         if (den == 0)
            return 0;
         return (2 * num + den) / (2 * den);
      endfunction

      function hsl_pixel_type convert_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                            logic [CH_W-1:0] b);
         hsl_pixel_type   px;
         logic [CH_W-1:0] hi, lo;
         bit [31:0]       spread, total, sector;
         px.red = r;
         px.green = g;
         px.blue = b;
         hi = r;
         lo = r;
         if (g > hi) hi = g;
         if (b > hi) hi = b;
         if (g < lo) lo = g;
         if (b < lo) lo = b;
         spread = 32'(hi) - 32'(lo);
         total  = 32'(hi) + 32'(lo);
         px.lightness  = CH_W'((total + 1) >> 1);
         px.hue        = '0;
         px.saturation = '0;
         // Gray pixels keep hue and saturation at zero
         if (spread != 0) begin
            if (total <= 255)
               px.saturation = CH_W'(round_half_up(255 * spread, total));
            else
               px.saturation = CH_W'(round_half_up(255 * spread, 510 - total));
            // Red wins ties, then green, then blue
            if (r == hi) begin
               if (g < b)
                  sector = 6 * spread - (32'(b) - 32'(g));
               else
                  sector = 32'(g) - 32'(b);
            end else if (g == hi) begin
               sector = 2 * spread + 32'(b) - 32'(r);
            end else begin
               sector = 4 * spread + 32'(r) - 32'(g);
            end
            px.hue = CH_W'(round_half_up(255 * sector, 6 * spread));
         end
         return px;
      endfunction

      function void report_failure(string text);
         fail_count++;
         if (fail_count <= REPORT_LIMIT)
            $display("[%0t] %s", $realtime, text);
      endfunction

      function void note_request(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                 logic [CH_W-1:0] b);
         pending_q.push_back(convert_pixel(r, g, b));
      endfunction

      function void check_response(logic [CH_W-1:0] h, logic [CH_W-1:0] l,
                                   logic [CH_W-1:0] s);
         hsl_pixel_type px;
         if (pending_q.size() == 0) begin
            report_failure($sformatf("unexpected response h/l/s=%0d/%0d/%0d", h, l, s));
            return;
         end
         px = pending_q.pop_front();
         if (h !== px.hue || l !== px.lightness || s !== px.saturation)
            report_failure($sformatf(
               "mismatch rgb=(%0d,%0d,%0d) expected h/l/s=%0d/%0d/%0d got %0d/%0d/%0d",
               px.red, px.green, px.blue, px.hue, px.lightness, px.saturation,
               h, l, s));
      endfunction

      function void check_drained();
         if (pending_q.size() != 0)
            report_failure($sformatf("%0d responses never arrived", pending_q.size()));
      endfunction

      function int unsigned pending();
         return pending_q.size();
      endfunction
   endclass

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            start = 1'b0;
   logic            busy;
   logic [CH_W-1:0] req_red = '0;
   logic [CH_W-1:0] req_green = '0;
   logic [CH_W-1:0] req_blue = '0;
   logic            rsp_valid;
   logic [CH_W-1:0] rsp_hue;
   logic [CH_W-1:0] rsp_lightness;
   logic [CH_W-1:0] rsp_saturation;

   hsl_scoreboard   sb = new();
   int unsigned     idle_cycles = 0;

   rgb_to_hsl_pixel_core DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_valid      (rsp_valid),
      .rsp_hue        (rsp_hue),
      .rsp_lightness  (rsp_lightness),
      .rsp_saturation (rsp_saturation)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Sample accepted requests and strobed responses at the clock edge
   always @(posedge clock) begin
      if (!reset) begin
         if (start === 1'b1 && busy === 1'b0)
            sb.note_request(req_red, req_green, req_blue);
         if (rsp_valid === 1'b1)
            sb.check_response(rsp_hue, rsp_lightness, rsp_saturation);
      end
   end

   // Abort when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // Present one request and hold it until the core takes it
   task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                             input logic [CH_W-1:0] b);
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      start     <= 1'b1;
      do
         @(posedge clock);
      while (busy !== 1'b0);
   endtask

   // Stop sending and wait until every predicted response has come back
   task automatic drain_responses();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   initial begin
      int unsigned sent, burst, gap, k, mode, pick;
      int          base, v;
      logic [CH_W-1:0] r, g, b, hi, lo;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, primaries, ties, gray, saturation boundary, hue wrap
      send_pixel(8'd0,   8'd0,   8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd255, 8'd0,   8'd0);
      send_pixel(8'd0,   8'd255, 8'd0);
      send_pixel(8'd0,   8'd0,   8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0,   8'd255, 8'd255);
      send_pixel(8'd255, 8'd0,   8'd255);
      send_pixel(8'd255, 8'd0,   8'd1);
      send_pixel(8'd200, 8'd10,  8'd11);
      send_pixel(8'd1,   8'd0,   8'd0);
      send_pixel(8'd0,   8'd1,   8'd0);
      send_pixel(8'd0,   8'd0,   8'd1);
      send_pixel(8'd255, 8'd254, 8'd254);
      send_pixel(8'd128, 8'd127, 8'd127);
      send_pixel(8'd129, 8'd127, 8'd127);
      send_pixel(8'd127, 8'd128, 8'd127);
      send_pixel(8'd127, 8'd127, 8'd129);
      send_pixel(8'd170, 8'd85,  8'd0);
      send_pixel(8'd85,  8'd170, 8'd255);
      send_pixel(8'd170, 8'd85,  8'd170);
      drain_responses();

      // Random bursts: mostly uniform pixels, some near gray, some with ties
      sent = 0;
      while (sent < RANDOM_PIXELS) begin
         burst = $urandom_range(1, 40);
         for (k = 0; k < burst && sent < RANDOM_PIXELS; k++) begin
            mode = $urandom_range(0, 9);
            if (mode <= 5) begin
               r = CH_W'($urandom);
               g = CH_W'($urandom);
               b = CH_W'($urandom);
            end else if (mode <= 7) begin
               base = $urandom_range(0, 255);
               v = base + $urandom_range(0, 4) - 2;
               r = CH_W'((v < 0) ? 0 : (v > 255) ? 255 : v);
               v = base + $urandom_range(0, 4) - 2;
               g = CH_W'((v < 0) ? 0 : (v > 255) ? 255 : v);
               v = base + $urandom_range(0, 4) - 2;
               b = CH_W'((v < 0) ? 0 : (v > 255) ? 255 : v);
            end else begin
               hi = CH_W'($urandom);
               lo = CH_W'($urandom);
               pick = $urandom_range(0, 2);
               r = (pick == 0) ? lo : hi;
               g = (pick == 1) ? lo : hi;
               b = (pick == 2) ? lo : hi;
            end
            send_pixel(r, g, b);
            sent++;
         end
         if ($urandom_range(0, 24) == 0) begin
            drain_responses();
         end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
               start <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end

      // Let the pipeline empty, then give stray responses a chance to show
      drain_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      sb.check_drained();
      if (sb.fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
